[hdl/tcgd_pkg.sv]
// Shared types, constants and helper functions for the touch contact gesture detector.
// Depends on nothing; every RTL file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tcgd_pkg;

    localparam int CONTACT_SLOTS = 10;
    localparam int SLOT_W        = $clog2(CONTACT_SLOTS);
    localparam int LIVE_W        = $clog2(CONTACT_SLOTS + 1);
    localparam int ID_W          = 32;
    localparam int COORD_W       = 16;
    localparam int TIME_W        = 32;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int ACC_W         = 24;
    localparam int DIST_W        = 17;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int RAD_W         = 34;
    localparam int SQRT_STEPS    = RAD_W / 2;
    localparam int STEP_W        = $clog2(SQRT_STEPS);
    localparam int PX_ONE        = 16;

    localparam logic [1:0] MODE_BEGIN  = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_END    = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PAN_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP  = 2'd2;

    localparam logic [CFG_W-1:0] PAN_THR_RST  = 16'd800;
    localparam logic [CFG_W-1:0] ZOOM_THR_RST = 16'd160;
    localparam logic [CFG_W-1:0] MIN_GAP_RST  = 16'd80;

    localparam logic signed [4:0] ZOOM_SPREAD = 5'sd10;
    localparam logic signed [4:0] ZOOM_CLOSE  = -5'sd10;
    localparam logic signed [3:0] PAN_POS     = 4'sd5;
    localparam logic signed [3:0] PAN_NEG     = -4'sd5;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] prev_x;
        logic [COORD_W-1:0] prev_y;
    } t_slot;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_RD0,
        ST_RD1,
        ST_GET1,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_PINCH,
        ST_PAN,
        ST_DONE
    } t_state;

    // Adds a signed step to an accumulator and saturates at the accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [DIFF_W:0]   val
    );
        logic signed [ACC_W:0] sum;
        sum = {acc[ACC_W-1], acc} + (ACC_W+1)'(val);
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return sum[ACC_W-1:0];
    endfunction

    // Difference of two unsigned coordinates as a signed value.
    function automatic logic signed [DIFF_W-1:0] coord_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

endpackage

`default_nettype wire

[hdl/touch_contact_gesture_detector.sv]
// Top level of the touch contact gesture detector: contact table memory, slot search,
// distance square root, pinch and pan detection. Depends on tcgd_pkg.
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  -----------------------------------------
//  event     in         i_in_valid / o_in_stall   i_mode, i_touch_id, i_pos_x, i_pos_y,
//                                                 i_event_time
//  result    out        o_out_valid / i_out_stall o_was_duplicate, o_zoom_fired, o_zoom_step,
//                                                 o_pan_fired, o_pan_dx, o_pan_dy,
//                                                 o_active_count
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A request is accepted in the idle state; the search then visits the contact slots in order,
// with a read state and a check state for each, since every slot comes from the table memory
// through a registered read port. A two-finger update then fetches slots 0 and 1, squares the
// offsets on one shared multiplier, runs the bit-pair square root and evaluates pinch, then pan.
// Reset is synchronous and active low; it clears the per-slot valid bits, so every slot
// reads as free and zero right away and no clearing pass is needed.
// A finished result sits in the output register; the next request is accepted while it
// waits, and the block holds at its end state only if that register is still full and the receiver stalls.
`timescale 1ns / 1ps
`default_nettype none

module touch_contact_gesture_detector (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [tcgd_pkg::ID_W-1:0]     i_touch_id,
    input  wire logic [tcgd_pkg::COORD_W-1:0]  i_pos_x,
    input  wire logic [tcgd_pkg::COORD_W-1:0]  i_pos_y,
    input  wire logic [tcgd_pkg::TIME_W-1:0]   i_event_time,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_was_duplicate,
    output logic                               o_zoom_fired,
    output logic signed [4:0]                  o_zoom_step,
    output logic                               o_pan_fired,
    output logic signed [3:0]                  o_pan_dx,
    output logic signed [3:0]                  o_pan_dy,
    output logic [3:0]                         o_active_count,
    input  wire logic                          i_cfg_we,
    input  wire logic [tcgd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tcgd_pkg::CFG_W-1:0]    i_cfg_data
);

    // Configuration registers.
    logic [tcgd_pkg::CFG_W-1:0] r_pan_thr;
    logic [tcgd_pkg::CFG_W-1:0] r_zoom_thr;
    logic [tcgd_pkg::CFG_W-1:0] r_min_gap;

    // Contact table: a memory with one write and one read port, plus a valid bit per
    // entry so that reset frees every slot at once.
    tcgd_pkg::t_slot r_mem [tcgd_pkg::CONTACT_SLOTS];
    logic [tcgd_pkg::CONTACT_SLOTS-1:0] r_slot_vld;
    tcgd_pkg::t_slot r_rd_data;
    logic            r_rd_vld;
    tcgd_pkg::t_slot rd_entry;
    logic [tcgd_pkg::SLOT_W-1:0] rd_addr;
    logic [tcgd_pkg::SLOT_W-1:0] wr_addr;
    logic            mem_we;
    tcgd_pkg::t_slot mem_wdata;

    tcgd_pkg::t_state r_state;
    tcgd_pkg::t_state n_state;

    // The request being worked on.
    logic [1:0]                   r_mode;
    logic [tcgd_pkg::ID_W-1:0]    r_id;
    logic [tcgd_pkg::COORD_W-1:0] r_x;
    logic [tcgd_pkg::COORD_W-1:0] r_y;
    logic [tcgd_pkg::SLOT_W-1:0]  r_idx;

    // Saved previous request, used to spot duplicates.
    logic                         r_rec_vld;
    logic [1:0]                   r_rec_mode;
    logic [tcgd_pkg::ID_W-1:0]    r_rec_id;
    logic [tcgd_pkg::COORD_W-1:0] r_rec_x;
    logic [tcgd_pkg::COORD_W-1:0] r_rec_y;
    logic [tcgd_pkg::TIME_W-1:0]  r_rec_time;

    // Gesture state.
    logic [tcgd_pkg::LIVE_W-1:0]        r_live;
    logic                               r_pinch_started;
    logic [tcgd_pkg::DIST_W-1:0]        r_prior_dist;
    logic signed [tcgd_pkg::ACC_W-1:0]  r_zoom_acc;
    logic signed [tcgd_pkg::ACC_W-1:0]  r_pan_acc_x;
    logic signed [tcgd_pkg::ACC_W-1:0]  r_pan_acc_y;

    // Slots 0 and 1 as they stand after the update.
    tcgd_pkg::t_slot r_s0;
    tcgd_pkg::t_slot r_s1;

    // Square root unit.
    logic [tcgd_pkg::RAD_W-1:0]  r_rad;
    logic [tcgd_pkg::RAD_W-1:0]  r_root;
    logic [tcgd_pkg::RAD_W-1:0]  r_bit;
    logic [tcgd_pkg::STEP_W-1:0] r_step;

    // Per-request result.
    logic              r_dup;
    logic signed [4:0] r_zstep;
    logic signed [3:0] r_pdx;
    logic signed [3:0] r_pdy;

    logic in_acc;
    logic acc_dup;
    logic acc_skip;
    logic slot_match;
    logic out_load;

    logic signed [tcgd_pkg::DIFF_W-1:0] sq_diff;
    logic [tcgd_pkg::COORD_W-1:0]       sq_mag;
    logic [2*tcgd_pkg::COORD_W-1:0]     sq_prod;
    logic [tcgd_pkg::RAD_W-1:0]         sqrt_trial;

    logic [tcgd_pkg::DIST_W-1:0]        cur_dist;
    logic signed [tcgd_pkg::DIST_W:0]   dist_delta;
    logic signed [tcgd_pkg::DIFF_W:0]   dist_clamped;
    logic signed [tcgd_pkg::ACC_W-1:0]  zoom_next;
    logic signed [tcgd_pkg::ACC_W:0]    zoom_cmp;
    logic signed [tcgd_pkg::ACC_W:0]    zoom_thr_s;
    logic                               zoom_pos;
    logic                               zoom_neg;

    logic signed [tcgd_pkg::DIFF_W-1:0] dx0, dx1, dy0, dy1;
    logic signed [tcgd_pkg::DIFF_W-1:0] mv_x, mv_y;
    logic signed [tcgd_pkg::ACC_W-1:0]  pan_x_next, pan_y_next;
    logic signed [tcgd_pkg::ACC_W:0]    pan_x_cmp, pan_y_cmp, pan_thr_s;
    logic [tcgd_pkg::DIFF_W-1:0]        gap_x, gap_y;
    logic                               x_pos, x_neg, y_pos, y_neg;
    logic                               x_fire, y_fire;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign acc_dup = r_rec_vld && (r_rec_mode == i_mode) && (r_rec_id == i_touch_id)
                     && (r_rec_x == i_pos_x) && (r_rec_y == i_pos_y)
                     && (r_rec_time == i_event_time);
    assign acc_skip = (i_mode == tcgd_pkg::MODE_NONE) || acc_dup
                      || (i_touch_id == '0);
    assign rd_entry = r_rd_vld ? r_rd_data : '0;
    // A begin looks for the first free slot; update and end look for the contact id.
    assign slot_match = (r_mode == tcgd_pkg::MODE_BEGIN) ? (rd_entry.id == '0)
                                                         : (rd_entry.id == r_id);
    assign out_load = !o_out_valid || !i_out_stall;

    // Squaring: one shared multiplier, x offset first, y offset next.
    assign sq_diff = (r_state == tcgd_pkg::ST_SQX)
                     ? tcgd_pkg::coord_diff(r_s1.pos_x, r_s0.prev_x)
                     : tcgd_pkg::coord_diff(r_s1.pos_y, r_s0.prev_y);
    assign sq_mag  = tcgd_pkg::COORD_W'(tcgd_pkg::mag(sq_diff));
    assign sq_prod = sq_mag * sq_mag;
    assign sqrt_trial = r_root + r_bit;

    // Pinch: clamp the distance change to one pixel and accumulate it.
    assign cur_dist   = r_root[tcgd_pkg::DIST_W-1:0];
    assign dist_delta = $signed({1'b0, r_prior_dist}) - $signed({1'b0, cur_dist});
    always_comb begin
        if (dist_delta > (tcgd_pkg::DIST_W+1)'(tcgd_pkg::PX_ONE)) begin
            dist_clamped = (tcgd_pkg::DIFF_W+1)'(tcgd_pkg::PX_ONE);
        end else if (dist_delta < -(tcgd_pkg::DIST_W+1)'(tcgd_pkg::PX_ONE)) begin
            dist_clamped = -(tcgd_pkg::DIFF_W+1)'(tcgd_pkg::PX_ONE);
        end else begin
            dist_clamped = (tcgd_pkg::DIFF_W+1)'(dist_delta);
        end
    end
    assign zoom_next  = tcgd_pkg::sat_add(r_zoom_acc, dist_clamped);
    assign zoom_cmp   = {zoom_next[tcgd_pkg::ACC_W-1], zoom_next};
    assign zoom_thr_s = $signed({{(tcgd_pkg::ACC_W+1-tcgd_pkg::CFG_W){1'b0}}, r_zoom_thr});
    assign zoom_pos   = zoom_cmp > zoom_thr_s;
    assign zoom_neg   = zoom_cmp < -zoom_thr_s;

    // Pan: per axis take the smaller finger movement, accumulate, and check the gap.
    assign dx0 = tcgd_pkg::coord_diff(r_s0.pos_x, r_s0.prev_x);
    assign dx1 = tcgd_pkg::coord_diff(r_s1.pos_x, r_s1.prev_x);
    assign dy0 = tcgd_pkg::coord_diff(r_s0.pos_y, r_s0.prev_y);
    assign dy1 = tcgd_pkg::coord_diff(r_s1.pos_y, r_s1.prev_y);
    assign mv_x = (tcgd_pkg::mag(dx0) < tcgd_pkg::mag(dx1)) ? dx0 : dx1;
    assign mv_y = (tcgd_pkg::mag(dy0) < tcgd_pkg::mag(dy1)) ? dy0 : dy1;
    assign pan_x_next = tcgd_pkg::sat_add(r_pan_acc_x, (tcgd_pkg::DIFF_W+1)'(mv_x));
    assign pan_y_next = tcgd_pkg::sat_add(r_pan_acc_y, (tcgd_pkg::DIFF_W+1)'(mv_y));
    assign pan_x_cmp  = {pan_x_next[tcgd_pkg::ACC_W-1], pan_x_next};
    assign pan_y_cmp  = {pan_y_next[tcgd_pkg::ACC_W-1], pan_y_next};
    assign pan_thr_s  = $signed({{(tcgd_pkg::ACC_W+1-tcgd_pkg::CFG_W){1'b0}}, r_pan_thr});
    assign gap_x = tcgd_pkg::mag(tcgd_pkg::coord_diff(r_s0.pos_x, r_s1.pos_x));
    assign gap_y = tcgd_pkg::mag(tcgd_pkg::coord_diff(r_s0.pos_y, r_s1.pos_y));
    assign x_pos = pan_x_cmp > pan_thr_s;
    assign x_neg = pan_x_cmp < -pan_thr_s;
    assign y_pos = pan_y_cmp > pan_thr_s;
    assign y_neg = pan_y_cmp < -pan_thr_s;
    assign x_fire = (gap_y > tcgd_pkg::DIFF_W'(r_min_gap)) && (x_pos || x_neg);
    // A horizontal step clears the accumulators, so the vertical check then finds zero.
    assign y_fire = !x_fire && (gap_x > tcgd_pkg::DIFF_W'(r_min_gap)) && (y_pos || y_neg);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcgd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = acc_skip ? tcgd_pkg::ST_DONE : tcgd_pkg::ST_SCAN_RD;
                end
            end
            tcgd_pkg::ST_SCAN_RD: n_state = tcgd_pkg::ST_SCAN_CHK;
            tcgd_pkg::ST_SCAN_CHK: begin
                if (slot_match) begin
                    if (r_mode == tcgd_pkg::MODE_UPDATE
                            && r_live == tcgd_pkg::LIVE_W'(2)) begin
                        n_state = tcgd_pkg::ST_RD0;
                    end else begin
                        n_state = tcgd_pkg::ST_DONE;
                    end
                end else if (r_idx == tcgd_pkg::SLOT_W'(tcgd_pkg::CONTACT_SLOTS - 1)) begin
                    n_state = tcgd_pkg::ST_DONE;
                end else begin
                    n_state = tcgd_pkg::ST_SCAN_RD;
                end
            end
            tcgd_pkg::ST_RD0:  n_state = tcgd_pkg::ST_RD1;
            tcgd_pkg::ST_RD1:  n_state = tcgd_pkg::ST_GET1;
            tcgd_pkg::ST_GET1: n_state = tcgd_pkg::ST_SQX;
            tcgd_pkg::ST_SQX:  n_state = tcgd_pkg::ST_SQY;
            tcgd_pkg::ST_SQY:  n_state = tcgd_pkg::ST_SQRT;
            tcgd_pkg::ST_SQRT: begin
                if (r_step == '0) begin
                    n_state = tcgd_pkg::ST_PINCH;
                end
            end
            tcgd_pkg::ST_PINCH: n_state = tcgd_pkg::ST_PAN;
            tcgd_pkg::ST_PAN:   n_state = tcgd_pkg::ST_DONE;
            tcgd_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = tcgd_pkg::ST_IDLE;
                end
            end
            default: n_state = tcgd_pkg::ST_IDLE;
        endcase
    end

    // Memory control and input handshake.
    always_comb begin
        o_in_stall = 1'b1;
        rd_addr    = r_idx;
        wr_addr    = r_idx;
        mem_we     = 1'b0;
        mem_wdata  = rd_entry;
        unique case (r_state)
            tcgd_pkg::ST_IDLE: o_in_stall = 1'b0;
            tcgd_pkg::ST_SCAN_CHK: begin
                if (slot_match) begin
                    mem_we = 1'b1;
                    unique case (r_mode)
                        tcgd_pkg::MODE_BEGIN: begin
                            mem_wdata.id    = r_id;
                            mem_wdata.pos_x = r_x;
                            mem_wdata.pos_y = r_y;
                        end
                        tcgd_pkg::MODE_UPDATE: begin
                            mem_wdata.prev_x = rd_entry.pos_x;
                            mem_wdata.prev_y = rd_entry.pos_y;
                            mem_wdata.pos_x  = r_x;
                            mem_wdata.pos_y  = r_y;
                        end
                        default: mem_wdata.id = '0;
                    endcase
                end
            end
            tcgd_pkg::ST_RD0: rd_addr = tcgd_pkg::SLOT_W'(0);
            tcgd_pkg::ST_RD1: rd_addr = tcgd_pkg::SLOT_W'(1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (mem_we) begin
                r_slot_vld[wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_slot_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_thr  <= tcgd_pkg::PAN_THR_RST;
            r_zoom_thr <= tcgd_pkg::ZOOM_THR_RST;
            r_min_gap  <= tcgd_pkg::MIN_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcgd_pkg::CFG_PAN_THR:  r_pan_thr  <= i_cfg_data;
                tcgd_pkg::CFG_ZOOM_THR: r_zoom_thr <= i_cfg_data;
                tcgd_pkg::CFG_MIN_GAP:  r_min_gap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer state and the gesture datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= tcgd_pkg::ST_IDLE;
            r_rec_vld       <= 1'b0;
            r_live          <= '0;
            r_pinch_started <= 1'b0;
            r_prior_dist    <= '0;
            r_zoom_acc      <= '0;
            r_pan_acc_x     <= '0;
            r_pan_acc_y     <= '0;
            o_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            // The result register fills when a request finishes and empties when taken.
            if (r_state == tcgd_pkg::ST_DONE && out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                tcgd_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_mode  <= i_mode;
                        r_id    <= i_touch_id;
                        r_x     <= i_pos_x;
                        r_y     <= i_pos_y;
                        r_idx   <= '0;
                        r_dup   <= acc_dup;
                        r_zstep <= '0;
                        r_pdx   <= '0;
                        r_pdy   <= '0;
                        if (i_mode != tcgd_pkg::MODE_NONE) begin
                            r_rec_vld  <= 1'b1;
                            r_rec_mode <= i_mode;
                            r_rec_id   <= i_touch_id;
                            r_rec_x    <= i_pos_x;
                            r_rec_y    <= i_pos_y;
                            r_rec_time <= i_event_time;
                        end
                    end
                end
                tcgd_pkg::ST_SCAN_CHK: begin
                    if (slot_match) begin
                        unique case (r_mode)
                            tcgd_pkg::MODE_BEGIN: r_live <= r_live + 1'b1;
                            tcgd_pkg::MODE_UPDATE: begin
                                if (r_live != tcgd_pkg::LIVE_W'(2)) begin
                                    r_pinch_started <= 1'b0;
                                end
                            end
                            default: begin
                                if (r_live != '0) begin
                                    r_live <= r_live - 1'b1;
                                end
                            end
                        endcase
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                tcgd_pkg::ST_RD1:  r_s0 <= rd_entry;
                tcgd_pkg::ST_GET1: r_s1 <= rd_entry;
                tcgd_pkg::ST_SQX: begin
                    r_rad <= tcgd_pkg::RAD_W'(sq_prod);
                end
                tcgd_pkg::ST_SQY: begin
                    r_rad  <= r_rad + tcgd_pkg::RAD_W'(sq_prod);
                    r_root <= '0;
                    r_bit  <= tcgd_pkg::RAD_W'(1) << (2 * (tcgd_pkg::SQRT_STEPS - 1));
                    r_step <= tcgd_pkg::STEP_W'(tcgd_pkg::SQRT_STEPS - 1);
                end
                tcgd_pkg::ST_SQRT: begin
                    // One bit pair of the root per cycle.
                    if (r_rad >= sqrt_trial) begin
                        r_rad  <= r_rad - sqrt_trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_step <= r_step - 1'b1;
                end
                tcgd_pkg::ST_PINCH: begin
                    r_prior_dist <= cur_dist;
                    if (!r_pinch_started) begin
                        // First two-finger update: only a nonzero distance arms the pinch.
                        r_pinch_started <= (cur_dist != '0);
                        r_zoom_acc      <= '0;
                        r_pan_acc_x     <= '0;
                        r_pan_acc_y     <= '0;
                    end else if (zoom_pos || zoom_neg) begin
                        r_zstep     <= zoom_pos ? tcgd_pkg::ZOOM_CLOSE : tcgd_pkg::ZOOM_SPREAD;
                        r_zoom_acc  <= '0;
                        r_pan_acc_x <= '0;
                        r_pan_acc_y <= '0;
                    end else begin
                        r_zoom_acc <= zoom_next;
                    end
                end
                tcgd_pkg::ST_PAN: begin
                    if (x_fire || y_fire) begin
                        r_zoom_acc  <= '0;
                        r_pan_acc_x <= '0;
                        r_pan_acc_y <= '0;
                    end else begin
                        r_pan_acc_x <= pan_x_next;
                        r_pan_acc_y <= pan_y_next;
                    end
                    if (x_fire) begin
                        r_pdx <= x_pos ? tcgd_pkg::PAN_POS : tcgd_pkg::PAN_NEG;
                        r_pdy <= '0;
                    end else if (y_fire) begin
                        r_pdx <= '0;
                        r_pdy <= y_pos ? tcgd_pkg::PAN_POS : tcgd_pkg::PAN_NEG;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result register, loaded when the request finishes.
    always_ff @(posedge i_clk) begin
        if (r_state == tcgd_pkg::ST_DONE && out_load) begin
            o_was_duplicate <= r_dup;
            o_zoom_fired    <= (r_zstep != '0);
            o_zoom_step     <= r_zstep;
            o_pan_fired     <= (r_pdx != '0) || (r_pdy != '0);
            o_pan_dx        <= r_pdx;
            o_pan_dy        <= r_pdy;
            o_active_count  <= 4'(r_live);
        end
    end

endmodule

`default_nettype wire

[tb/touch_contact_gesture_detector_tb.sv]
// Self-checking testbench for the touch contact gesture detector: directed and random
// touch events, a behavioral predictor of the contact table and gestures. Depends on tcgd_pkg.
`timescale 1ns / 1ps

module touch_contact_gesture_detector_tb;

    localparam int IDLE_LIMIT = 20000;

    // One expected gesture result per touch request.
    typedef struct packed {
        logic             dup;
        logic             zf;
        logic signed [4:0] zs;
        logic             pf;
        logic signed [3:0] pdx;
        logic signed [3:0] pdy;
        logic [3:0]       cnt;
    } t_gesture;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_stall;
    logic [1:0] i_mode;
    logic [31:0] i_touch_id, i_event_time;
    logic [15:0] i_pos_x, i_pos_y;
    logic o_out_valid, i_out_stall;
    logic o_was_duplicate, o_zoom_fired, o_pan_fired;
    logic signed [4:0] o_zoom_step;
    logic signed [3:0] o_pan_dx, o_pan_dy;
    logic [3:0] o_active_count;
    logic i_cfg_we;
    logic [tcgd_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [tcgd_pkg::CFG_W-1:0] i_cfg_data;

    touch_contact_gesture_detector uut (.*);

    always begin
        i_clk = 1'b0; #1;
        i_clk = 1'b1; #1;
    end

    // Predictor state: a mirror of the contact table and gesture accumulators.
    int unsigned pm_pan_thr, pm_zoom_thr, pm_gap;
    logic [31:0] tbl_id [tcgd_pkg::CONTACT_SLOTS];
    int tbl_x [tcgd_pkg::CONTACT_SLOTS], tbl_y [tcgd_pkg::CONTACT_SLOTS];
    int tbl_px [tcgd_pkg::CONTACT_SLOTS], tbl_py [tcgd_pkg::CONTACT_SLOTS];
    int live, prior_dist, zacc, pacc_x, pacc_y;
    bit pinching, rec_ok;
    logic [97:0] last_event;

    t_gesture expected_q[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0, stall_pct = 0;
    bit hold_off = 0;
    bit stim_done = 0;

    // Touch ids used by the random traffic come from a small pool so updates hit live contacts.
    logic [31:0] id_pool [6] = '{32'd1, 32'd2, 32'hFFFF_FFFF, 32'h8000_0000, 32'd7, 32'd3};

    function automatic int sat24(int v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic int absv(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int isqrt(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 34;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return int'(r);
    endfunction

    task automatic clear_accums();
        zacc = 0; pacc_x = 0; pacc_y = 0;
    endtask

    task automatic reset_predictor();
        pm_pan_thr = 32'(tcgd_pkg::PAN_THR_RST);
        pm_zoom_thr = 32'(tcgd_pkg::ZOOM_THR_RST);
        pm_gap = 32'(tcgd_pkg::MIN_GAP_RST);
        for (int i = 0; i < tcgd_pkg::CONTACT_SLOTS; i++) begin
            tbl_id[i] = '0; tbl_x[i] = 0; tbl_y[i] = 0; tbl_px[i] = 0; tbl_py[i] = 0;
        end
        live = 0; pinching = 0; prior_dist = 0; rec_ok = 0; last_event = '0;
        clear_accums();
    endtask

    // Pinch then pan on slots 0 and 1, whichever slot was updated.
    task automatic predict_gestures(inout t_gesture g);
        int dx, dy, d, delta, mx, my, gx, gy, thr, gap;
        longint sq;
        if (live != 2) begin
            pinching = 0;
            return;
        end
        dx = tbl_x[1] - tbl_px[0];
        dy = tbl_y[1] - tbl_py[0];
        sq = longint'(dx) * dx + longint'(dy) * dy;
        d = isqrt(64'(sq));
        if (!pinching) begin
            pinching = d > 0;
            prior_dist = d;
            clear_accums();
        end else begin
            delta = prior_dist - d;
            if (delta > tcgd_pkg::PX_ONE) delta = tcgd_pkg::PX_ONE;
            if (delta < -tcgd_pkg::PX_ONE) delta = -tcgd_pkg::PX_ONE;
            zacc = sat24(zacc + delta);
            prior_dist = d;
            if (zacc > int'(pm_zoom_thr)) begin
                g.zs = tcgd_pkg::ZOOM_CLOSE; clear_accums();
            end
            if (zacc < -int'(pm_zoom_thr)) begin
                g.zs = tcgd_pkg::ZOOM_SPREAD; clear_accums();
            end
        end
        // Pan takes the finger that moved less on each axis.
        dx = tbl_x[0] - tbl_px[0]; mx = tbl_x[1] - tbl_px[1];
        dy = tbl_y[0] - tbl_py[0]; my = tbl_y[1] - tbl_py[1];
        pacc_x = sat24(pacc_x + (absv(dx) < absv(mx) ? dx : mx));
        pacc_y = sat24(pacc_y + (absv(dy) < absv(my) ? dy : my));
        gx = absv(tbl_x[0] - tbl_x[1]);
        gy = absv(tbl_y[0] - tbl_y[1]);
        thr = int'(pm_pan_thr); gap = int'(pm_gap);
        if (gy > gap) begin
            if (pacc_x > thr) begin
                g.pdx = tcgd_pkg::PAN_POS; g.pdy = '0; clear_accums();
            end else if (pacc_x < -thr) begin
                g.pdx = tcgd_pkg::PAN_NEG; g.pdy = '0; clear_accums();
            end
        end
        if (gx > gap) begin
            if (pacc_y > thr) begin
                g.pdx = '0; g.pdy = tcgd_pkg::PAN_POS; clear_accums();
            end else if (pacc_y < -thr) begin
                g.pdx = '0; g.pdy = tcgd_pkg::PAN_NEG; clear_accums();
            end
        end
    endtask

    task automatic predict_event(logic [1:0] m, logic [31:0] id, logic [15:0] x,
                                 logic [15:0] y, logic [31:0] t);
        t_gesture g;
        logic [97:0] ev;
        g = '0;
        ev = {m, id, x, y, t};
        if (m != tcgd_pkg::MODE_NONE) begin
            g.dup = rec_ok && (last_event == ev);
            rec_ok = 1;
            last_event = ev;
            if (!g.dup && id != 0) begin
                for (int i = 0; i < tcgd_pkg::CONTACT_SLOTS; i++) begin
                    if (m == tcgd_pkg::MODE_BEGIN && tbl_id[i] == 0) begin
                        tbl_id[i] = id; tbl_x[i] = int'(x); tbl_y[i] = int'(y);
                        live++;
                        break;
                    end
                    if (m == tcgd_pkg::MODE_UPDATE && tbl_id[i] == id) begin
                        tbl_px[i] = tbl_x[i]; tbl_py[i] = tbl_y[i];
                        tbl_x[i] = int'(x); tbl_y[i] = int'(y);
                        predict_gestures(g);
                        break;
                    end
                    if (m == tcgd_pkg::MODE_END && tbl_id[i] == id) begin
                        tbl_id[i] = '0;
                        if (live > 0) live--;
                        break;
                    end
                end
            end
        end
        g.zf = g.zs != 0;
        g.pf = (g.pdx != 0) || (g.pdy != 0);
        g.cnt = live[3:0];
        expected_q.push_back(g);
    endtask

    // Sends one touch request and records its expected result once it is accepted.
    // Valid stays high afterwards; the next send or a drain decides its next value.
    task automatic send_touch(logic [1:0] m, logic [31:0] id, logic [15:0] x,
                              logic [15:0] y, logic [31:0] t);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= m; i_touch_id <= id; i_pos_x <= x; i_pos_y <= y; i_event_time <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_event(m, id, x, y, t);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [tcgd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        wait_drained();
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tcgd_pkg::CFG_PAN_THR:  pm_pan_thr = 32'(val);
            tcgd_pkg::CFG_ZOOM_THR: pm_zoom_thr = 32'(val);
            default:                pm_gap = 32'(val);
        endcase
    endtask

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_gesture got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_was_duplicate, o_zoom_fired, o_zoom_step, o_pan_fired,
                   o_pan_dx, o_pan_dy, o_active_count};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected dup %b zf %b zs %0d pf %b dx %0d ",
                                  "dy %0d cnt %0d, got dup %b zf %b zs %0d pf %b dx %0d ",
                                  "dy %0d cnt %0d"},
                                 want.dup, want.zf, want.zs, want.pf, want.pdx, want.pdy,
                                 want.cnt, got.dup, got.zf, got.zs, got.pf, got.pdx,
                                 got.pdy, got.cnt);
                end
            end
        end
    end

    // Receiver stall, driven at the falling edge.
    always @(negedge i_clk) begin
        i_out_stall <= hold_off || (stall_pct != 0 && $urandom_range(99) < stall_pct);
    end

    // Watchdog on cycles with no accepted request or result.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("touch_contact_gesture_detector_tb: FAIL");
            $finish;
        end
    end

    int stamp = 1;

    // Edge cases: id zero, mode three, duplicates, full table, unknown ids, repeated begin.
    task automatic test_directed();
        send_touch(tcgd_pkg::MODE_BEGIN, 32'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_touch(tcgd_pkg::MODE_NONE, 32'd5, 16'd1, 16'd1, 32'd1);
        send_touch(tcgd_pkg::MODE_BEGIN, 32'd1, 16'd0, 16'd0, 32'd0);
        send_touch(tcgd_pkg::MODE_BEGIN, 32'd1, 16'd0, 16'd0, 32'd0);
        send_touch(tcgd_pkg::MODE_UPDATE, 32'd9, 16'd5, 16'd5, 32'd2);
        send_touch(tcgd_pkg::MODE_BEGIN, 32'd1, 16'd100, 16'd100, 32'd3);
        send_touch(tcgd_pkg::MODE_UPDATE, 32'd1, 16'd4000, 16'd10, 32'd4);
        send_touch(tcgd_pkg::MODE_UPDATE, 32'd1, 16'd4000, 16'd10, 32'd5);
        send_touch(tcgd_pkg::MODE_END, 32'd0, 16'd0, 16'd0, 32'd6);
        for (int i = 0; i < tcgd_pkg::CONTACT_SLOTS + 1; i++)
            send_touch(tcgd_pkg::MODE_BEGIN, 32'h100 + i, 16'(i * 900),
                       16'hFFFF - 16'(i), 32'd7 + i);
        send_touch(tcgd_pkg::MODE_END, 32'hABCD, 16'd0, 16'd0, 32'd20);
        for (int i = 0; i < tcgd_pkg::CONTACT_SLOTS; i++)
            send_touch(tcgd_pkg::MODE_END, 32'd1, 16'd0, 16'd0, 32'd30 + i);
        for (int i = 0; i < tcgd_pkg::CONTACT_SLOTS + 1; i++)
            send_touch(tcgd_pkg::MODE_END, 32'h100 + i, 16'd0, 16'd0, 32'd50 + i);
    endtask

    // Two-finger sequences: begin two contacts, move them, end them; some noise mixed in.
    task automatic test_gestures(int n);
        int sent = 0;
        int cx, cy, steps;
        logic [31:0] a, b, id;
        while (sent < n) begin
            if ($urandom_range(9) == 0) begin
                id = $urandom_range(3) == 0 ? $urandom : id_pool[$urandom_range(5)];
                send_touch(2'($urandom_range(3)), id, 16'($urandom), 16'($urandom),
                           $urandom);
                sent++;
                continue;
            end
            a = id_pool[$urandom_range(5)];
            b = id_pool[$urandom_range(5)];
            cx = $urandom_range(60000); cy = $urandom_range(60000);
            send_touch(tcgd_pkg::MODE_BEGIN, a, 16'(cx), 16'(cy), 32'(stamp++));
            send_touch(tcgd_pkg::MODE_BEGIN, b, 16'(cx + $urandom_range(3000)),
                       16'(cy + $urandom_range(3000)), 32'(stamp++));
            steps = $urandom_range(4, 30);
            for (int s = 0; s < steps; s++) begin
                id = $urandom_range(1) ? a : b;
                if ($urandom_range(19) == 0) begin
                    // Repeat the saved event exactly to exercise duplicates.
                    send_touch(last_event[97:96], last_event[95:64], last_event[63:48],
                               last_event[47:32], last_event[31:0]);
                end else begin
                    send_touch(tcgd_pkg::MODE_UPDATE, id, 16'(cx + $urandom_range(4000)),
                               16'(cy + $urandom_range(4000)), 32'(stamp++));
                    if ($urandom_range(7) == 0) cx = cx + $urandom_range(2000) - 1000;
                end
            end
            send_touch(tcgd_pkg::MODE_END, a, 16'd0, 16'd0, 32'(stamp++));
            send_touch(tcgd_pkg::MODE_END, b, 16'd0, 16'd0, 32'(stamp++));
            sent += steps + 4;
            if (live > 4) begin
                for (int i = 0; i < tcgd_pkg::CONTACT_SLOTS; i++)
                    if (tbl_id[i] != 0)
                        send_touch(tcgd_pkg::MODE_END, tbl_id[i], 16'd0, 16'd0,
                                   32'(stamp++));
            end
        end
    endtask

    // Long receiver hold-off while requests keep coming, then a full drain.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                repeat (400) @(negedge i_clk);
                hold_off = 0;
            end
            test_gestures(40);
        join
        wait_drained();
    endtask

    task automatic test_config_sweep();
        write_reg(tcgd_pkg::CFG_PAN_THR, 16'd0);
        write_reg(tcgd_pkg::CFG_ZOOM_THR, 16'd0);
        write_reg(tcgd_pkg::CFG_MIN_GAP, 16'd0);
        test_gestures(200);
        write_reg(tcgd_pkg::CFG_PAN_THR, 16'hFFFF);
        write_reg(tcgd_pkg::CFG_ZOOM_THR, 16'hFFFF);
        write_reg(tcgd_pkg::CFG_MIN_GAP, 16'hFFFF);
        test_gestures(100);
        write_reg(tcgd_pkg::CFG_PAN_THR, 16'd40);
        write_reg(tcgd_pkg::CFG_ZOOM_THR, 16'd8);
        write_reg(tcgd_pkg::CFG_MIN_GAP, 16'd16);
    endtask

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_mode = '0; i_touch_id = '0;
        i_pos_x = '0; i_pos_y = '0; i_event_time = '0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        reset_predictor();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_gestures(300);
        send_idle_pct = 48;
        test_gestures(250);
        send_idle_pct = 0; stall_pct = 48;
        test_gestures(250);
        send_idle_pct = 37; stall_pct = 37;
        test_gestures(250);
        stall_pct = 0; send_idle_pct = 0;
        test_backpressure();
        test_config_sweep();
        send_idle_pct = 37; stall_pct = 37;
        test_gestures(250);
        send_idle_pct = 0; stall_pct = 0;

        wait_drained();
        stim_done = 1;
        if (mismatches == 0 && expected_q.size() == 0)
            $display("touch_contact_gesture_detector_tb: PASS");
        else
            $display("touch_contact_gesture_detector_tb: FAIL");
        $finish;
    end

endmodule

[files.f]
hdl/tcgd_pkg.sv
hdl/touch_contact_gesture_detector.sv
tb/touch_contact_gesture_detector_tb.sv
